>>> rtl/uvcr_pkg.sv
package uvcr_pkg;

  // buffer and store sizes
  localparam int EP0_BUFFER_BYTES = 4096;
  localparam int EDID_BYTES       = 128;
  localparam int EDID_AW          = $clog2(EDID_BYTES);
  localparam int LEN_W            = 13;
  localparam int POS_W            = 12;
  localparam int VDESC_BYTES      = 12;
  localparam int VDESC_LEN        = (VDESC_BYTES < EP0_BUFFER_BYTES) ? VDESC_BYTES
                                                                     : EP0_BUFFER_BYTES;
  localparam int COMPAT_LEN       = 16;
  localparam int COMPAT_HDR_BYTES = 8;
  localparam int WORD_LEN         = 4;
  localparam int EDID_MIN_LEN     = 2;

  // mode codes
  localparam logic [1:0] MODE_SETUP   = 2'd0;
  localparam logic [1:0] MODE_FETCH   = 2'd1;
  localparam logic [1:0] MODE_DISABLE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_IN_READY = 2'd0;
  localparam logic [1:0] ST_OUT_ACK  = 2'd1;
  localparam logic [1:0] ST_STALL    = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  // request type bytes
  localparam logic [7:0] RT_STD_IN   = 8'h80;
  localparam logic [7:0] RT_VEND_IN  = 8'hc0;
  localparam logic [7:0] RT_VEND_OUT = 8'h40;

  // request codes
  localparam logic [7:0] RQ_COMPAT   = 8'h01;
  localparam logic [7:0] RQ_EDID     = 8'h02;
  localparam logic [7:0] RQ_POKE     = 8'h03;
  localparam logic [7:0] RQ_PEEK     = 8'h04;
  localparam logic [7:0] RQ_QUERY    = 8'h05;
  localparam logic [7:0] RQ_GET_DESC = 8'h06;
  localparam logic [7:0] RQ_KEY      = 8'h12;
  localparam logic [7:0] RQ_STATUS   = 8'h13;
  localparam logic [7:0] RQ_PULSE    = 8'h14;

  localparam logic [7:0]  DESC_VENDOR    = 8'h5f;
  localparam logic [7:0]  EDID_INDEX_TAG = 8'ha1;
  localparam logic [15:0] QUERY_INDEX    = 16'h0002;
  localparam logic [15:0] COMPAT_INDEX   = 16'h0004;
  localparam logic [15:0] ALL_ONES16     = 16'hffff;
  localparam logic [31:0] PROBE_WORD     = 32'hf0005000;
  localparam logic [31:0] QUERY_WORD     = 32'h00000f2b;
  localparam logic [31:0] STATUS_IDLE    = 32'h00000001;

  typedef enum logic [3:0] {
    KIND_NONE   = 4'd0,
    KIND_VDESC  = 4'd1,
    KIND_PROBE  = 4'd2,
    KIND_QUERY  = 4'd3,
    KIND_STATUS = 4'd4,
    KIND_COMPAT = 4'd5,
    KIND_PEEK   = 4'd6,
    KIND_POKE   = 4'd7,
    KIND_EDID   = 4'd8,
    KIND_KEY    = 4'd9,
    KIND_PULSE  = 4'd10
  } kind_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       request_type;
    logic [7:0]       request_code;
    logic [15:0]      request_value;
    logic [15:0]      request_index;
    logic [15:0]      request_length;
    logic [POS_W-1:0] byte_position;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] reply_length;
    logic             short_reply;
    logic [7:0]       data_byte;
  } out_t;

  // partial result after decode, waiting for the store read
  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] reply_length;
    logic             short_reply;
    logic [7:0]       data_byte;
    logic             use_mem;
  } stage_t;

  typedef struct packed {
    logic               rd_en;
    logic [EDID_AW-1:0] rd_addr;
  } mem_req_t;

  localparam logic [7:0] EDID_INIT [EDID_BYTES] = '{
    8'h00,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'h00, 8'h08,8'h58,8'h01,8'h00,8'h01,8'h00,8'h00,8'h00,
    8'h01,8'h22,8'h01,8'h03,8'h81,8'ha0,8'h5a,8'h78, 8'h0f,8'hee,8'h91,8'ha3,8'h54,8'h4c,8'h99,8'h26,
    8'h0f,8'h50,8'h54,8'h00,8'h00,8'h00,8'h01,8'h01, 8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h02,8'h3a, 8'h80,8'h18,8'h71,8'h38,8'h2d,8'h40,8'h58,8'h2c,
    8'h45,8'h00,8'h40,8'h84,8'h63,8'h00,8'h00,8'h1e, 8'h00,8'h00,8'h00,8'hfc,8'h00,8'h42,8'h72,8'h65,
    8'h65,8'h7a,8'h79,8'h20,8'h42,8'h6f,8'h78,8'h0a, 8'h20,8'h20,8'h00,8'h00,8'h00,8'hfd,8'h00,8'h32,
    8'h46,8'h1e,8'h46,8'h0f,8'h00,8'h0a,8'h20,8'h20, 8'h20,8'h20,8'h20,8'h20,8'h00,8'h00,8'h00,8'h10,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

  localparam logic [7:0] VDESC_INIT [VDESC_BYTES] = '{
    8'd12, 8'h5f, 8'h01, 8'h00, 8'd10, 8'h00, 8'h02, 8'd4, 8'h00, 8'ha4, 8'h1f, 8'h00
  };

  localparam logic [7:0] COMPAT_HDR [COMPAT_HDR_BYTES] = '{
    8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h04, 8'h00
  };

  // last edid byte makes the byte sum zero
  function automatic logic [7:0] edid_checksum();
    logic [7:0] sum;
    sum = 8'h00;
    for (int i = 0; i < EDID_BYTES - 1; i++) begin
      sum = sum + EDID_INIT[i];
    end
    return 8'(8'h00 - sum);
  endfunction

  localparam logic [7:0] EDID_CSUM = edid_checksum();

  function automatic logic [7:0] edid_init_byte(logic [EDID_AW-1:0] a);
    return (a == EDID_AW'(EDID_BYTES - 1)) ? EDID_CSUM : EDID_INIT[a];
  endfunction

endpackage

>>> rtl/uvcr_edid_mem.sv
module uvcr_edid_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  uvcr_pkg::mem_req_t         req,
  output logic [7:0]                 rd_data,
  output logic                       busy
);

  logic [7:0]                   mem [uvcr_pkg::EDID_BYTES];
  logic [uvcr_pkg::EDID_AW-1:0] fill_cnt_r;
  logic                         fill_done_r;
  logic [7:0]                   rd_data_r;

  // fill sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r  <= '0;
      fill_done_r <= 1'b0;
    end else if (!fill_done_r) begin
      fill_cnt_r <= fill_cnt_r + 1'b1;
      if (fill_cnt_r == uvcr_pkg::EDID_AW'(uvcr_pkg::EDID_BYTES - 1)) begin
        fill_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!fill_done_r) begin
      mem[fill_cnt_r] <= uvcr_pkg::edid_init_byte(fill_cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = !fill_done_r;

endmodule

>>> rtl/uvcr_ctrl.sv
module uvcr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  uvcr_pkg::in_t       in_item,
  output uvcr_pkg::stage_t    result,
  output uvcr_pkg::mem_req_t  mem_req
);

  logic                       key_r, key_nxt;
  uvcr_pkg::kind_t            kind_r, kind_nxt;
  logic                       snap_r, snap_nxt;
  logic [7:0]                 offset_r, offset_nxt;
  logic [uvcr_pkg::LEN_W-1:0] len_r, len_nxt;

  uvcr_pkg::kind_t            dec_kind;
  logic [uvcr_pkg::LEN_W-1:0] dec_len;
  logic [uvcr_pkg::LEN_W-1:0] len_sat;
  logic                       vin, vout;
  logic [15:0]                wval, widx, wlen;
  logic [7:0]                 rq;
  logic [uvcr_pkg::POS_W-1:0] pos;
  logic [uvcr_pkg::LEN_W-1:0] edid_idx;
  logic [31:0]                word;
  logic                       word_sel;
  logic [7:0]                 fetch_data;
  logic                       fetch_mem;

  assign wval = in_item.request_value;
  assign widx = in_item.request_index;
  assign wlen = in_item.request_length;
  assign rq   = in_item.request_code;
  assign pos  = in_item.byte_position;
  assign vin  = (in_item.request_type == uvcr_pkg::RT_VEND_IN);
  assign vout = (in_item.request_type == uvcr_pkg::RT_VEND_OUT);

  assign len_sat = (wlen > 16'(uvcr_pkg::EP0_BUFFER_BYTES))
                 ? uvcr_pkg::LEN_W'(uvcr_pkg::EP0_BUFFER_BYTES)
                 : wlen[uvcr_pkg::LEN_W-1:0];

  // setup decode, first match wins
  always_comb begin
    dec_kind = uvcr_pkg::KIND_NONE;
    dec_len  = '0;
    if (in_item.request_type == uvcr_pkg::RT_STD_IN && rq == uvcr_pkg::RQ_GET_DESC &&
        wval[15:8] == uvcr_pkg::DESC_VENDOR) begin
      dec_kind = uvcr_pkg::KIND_VDESC;
      dec_len  = (wlen < 16'(uvcr_pkg::VDESC_LEN)) ? wlen[uvcr_pkg::LEN_W-1:0]
                                                    : uvcr_pkg::LEN_W'(uvcr_pkg::VDESC_LEN);
    end else if (vin && rq == uvcr_pkg::RQ_GET_DESC && wlen == 16'(uvcr_pkg::WORD_LEN)) begin
      dec_kind = uvcr_pkg::KIND_PROBE;
      dec_len  = uvcr_pkg::LEN_W'(uvcr_pkg::WORD_LEN);
    end else if (vin && rq == uvcr_pkg::RQ_QUERY && widx == uvcr_pkg::QUERY_INDEX &&
                 wlen == 16'(uvcr_pkg::WORD_LEN)) begin
      dec_kind = uvcr_pkg::KIND_QUERY;
      dec_len  = uvcr_pkg::LEN_W'(uvcr_pkg::WORD_LEN);
    end else if (vin && rq == uvcr_pkg::RQ_STATUS && wval == uvcr_pkg::ALL_ONES16 &&
                 widx == uvcr_pkg::ALL_ONES16 && wlen == 16'(uvcr_pkg::WORD_LEN)) begin
      dec_kind = uvcr_pkg::KIND_STATUS;
      dec_len  = uvcr_pkg::LEN_W'(uvcr_pkg::WORD_LEN);
    end else if (vin && rq == uvcr_pkg::RQ_COMPAT && widx == uvcr_pkg::COMPAT_INDEX) begin
      dec_kind = uvcr_pkg::KIND_COMPAT;
      dec_len  = (wlen < 16'(uvcr_pkg::COMPAT_LEN)) ? wlen[uvcr_pkg::LEN_W-1:0]
                                                     : uvcr_pkg::LEN_W'(uvcr_pkg::COMPAT_LEN);
    end else if (vin && rq == uvcr_pkg::RQ_PEEK && wlen == 16'd1) begin
      dec_kind = uvcr_pkg::KIND_PEEK;
      dec_len  = uvcr_pkg::LEN_W'(1);
    end else if (vout && rq == uvcr_pkg::RQ_POKE && wlen == 16'd1) begin
      dec_kind = uvcr_pkg::KIND_POKE;
      dec_len  = uvcr_pkg::LEN_W'(1);
    end else if (vin && rq == uvcr_pkg::RQ_EDID && widx[7:0] == uvcr_pkg::EDID_INDEX_TAG) begin
      dec_kind = uvcr_pkg::KIND_EDID;
      dec_len  = (len_sat < uvcr_pkg::LEN_W'(uvcr_pkg::EDID_MIN_LEN))
               ? uvcr_pkg::LEN_W'(uvcr_pkg::EDID_MIN_LEN) : len_sat;
    end else if (vout && rq == uvcr_pkg::RQ_KEY) begin
      dec_kind = uvcr_pkg::KIND_KEY;
      dec_len  = len_sat;
    end else if (vout && rq == uvcr_pkg::RQ_PULSE) begin
      dec_kind = uvcr_pkg::KIND_PULSE;
      dec_len  = len_sat;
    end
  end

  // reply byte from the stored reply
  assign edid_idx = uvcr_pkg::LEN_W'(offset_r) + uvcr_pkg::LEN_W'(pos) - uvcr_pkg::LEN_W'(1);

  always_comb begin
    word       = '0;
    word_sel   = 1'b0;
    fetch_data = '0;
    fetch_mem  = 1'b0;
    case (kind_r)
      uvcr_pkg::KIND_PROBE: begin
        word     = uvcr_pkg::PROBE_WORD;
        word_sel = 1'b1;
      end
      uvcr_pkg::KIND_QUERY: begin
        word     = snap_r ? uvcr_pkg::QUERY_WORD : '0;
        word_sel = 1'b1;
      end
      uvcr_pkg::KIND_STATUS: begin
        word     = snap_r ? '0 : uvcr_pkg::STATUS_IDLE;
        word_sel = 1'b1;
      end
      default: begin
      end
    endcase
    if ({1'b0, pos} < len_r) begin
      case (kind_r)
        uvcr_pkg::KIND_VDESC: begin
          if (pos < uvcr_pkg::POS_W'(uvcr_pkg::VDESC_BYTES)) begin
            fetch_data = uvcr_pkg::VDESC_INIT[pos[3:0]];
          end
        end
        uvcr_pkg::KIND_COMPAT: begin
          if (pos < uvcr_pkg::POS_W'(uvcr_pkg::COMPAT_HDR_BYTES)) begin
            fetch_data = uvcr_pkg::COMPAT_HDR[pos[2:0]];
          end
        end
        uvcr_pkg::KIND_EDID: begin
          fetch_mem = (pos != '0) && (edid_idx < uvcr_pkg::LEN_W'(uvcr_pkg::EDID_BYTES));
        end
        default: begin
          if (word_sel && pos < uvcr_pkg::POS_W'(uvcr_pkg::WORD_LEN)) begin
            fetch_data = word[{pos[1:0], 3'b000} +: 8];
          end
        end
      endcase
    end
  end

  always_comb begin
    key_nxt    = key_r;
    kind_nxt   = kind_r;
    snap_nxt   = snap_r;
    offset_nxt = offset_r;
    len_nxt    = len_r;
    result     = '{status: uvcr_pkg::ST_DONE, reply_length: '0, short_reply: 1'b0,
                   data_byte: '0, use_mem: 1'b0};
    if (in_item.mode == uvcr_pkg::MODE_SETUP) begin
      kind_nxt   = dec_kind;
      snap_nxt   = key_r;
      offset_nxt = wval[15:8];
      if (dec_kind == uvcr_pkg::KIND_NONE) begin
        result.status = uvcr_pkg::ST_STALL;
        len_nxt       = '0;
      end else begin
        len_nxt             = dec_len;
        result.reply_length = dec_len;
        result.short_reply  = ({3'b000, dec_len} < wlen);
        result.status = (dec_kind == uvcr_pkg::KIND_POKE || dec_kind == uvcr_pkg::KIND_KEY ||
                         dec_kind == uvcr_pkg::KIND_PULSE) ? uvcr_pkg::ST_OUT_ACK
                                                           : uvcr_pkg::ST_IN_READY;
      end
      if (dec_kind == uvcr_pkg::KIND_KEY) begin
        key_nxt = 1'b1;
      end
    end else if (in_item.mode == uvcr_pkg::MODE_FETCH) begin
      result.data_byte = fetch_data;
      result.use_mem   = fetch_mem;
    end else if (in_item.mode == uvcr_pkg::MODE_DISABLE) begin
      key_nxt = 1'b0;
    end
  end

  assign mem_req.rd_en   = accept && (in_item.mode == uvcr_pkg::MODE_FETCH);
  assign mem_req.rd_addr = edid_idx[uvcr_pkg::EDID_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= 1'b0;
      kind_r   <= uvcr_pkg::KIND_NONE;
      snap_r   <= 1'b0;
      offset_r <= '0;
      len_r    <= '0;
    end else if (accept) begin
      key_r    <= key_nxt;
      kind_r   <= kind_nxt;
      snap_r   <= snap_nxt;
      offset_r <= offset_nxt;
      len_r    <= len_nxt;
    end
  end

endmodule

>>> rtl/usb_vendor_control_responder_top.sv
// control endpoint responder for a vendor display device
// input channel in_valid/in_ready/in_data carries one item per transfer:
//   a setup packet, a reply byte fetch by position, or a function disable event
// result channel out_valid/out_ready/out_data returns exactly one result per item
//   setup: status, data-stage length and short-reply flag
//   fetch: the reply byte at the given position of the last decoded reply
// each result is registered in the decode register and then in the output register
// throughput: one item per cycle while out_ready is high; the decode stage and the
//   edid store read run in parallel, the store has one registered read port
// a decode register and an output register sit between the channels, so a new
//   item is taken while a finished result waits on a stalled receiver; with both
//   full, in_ready drops until out_ready frees the output register
// reset: key flag and stored reply are cleared; the edid store is then loaded
//   from its fixed contents, one byte a cycle, so in_ready stays low until all 128
//   bytes are loaded after reset is released
// the key flag and reply state update at the input transfer, so a fetch or disable
//   right after a setup packet sees its effect
module usb_vendor_control_responder_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  uvcr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output uvcr_pkg::out_t out_data
);

  logic               accept;
  uvcr_pkg::stage_t   dec_result;
  uvcr_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rd_data;
  logic               mem_busy;

  // decode stage register
  logic               s1_valid_r;
  uvcr_pkg::stage_t   s1_r;
  logic               s1_adv;

  // output register
  logic               out_valid_r;
  uvcr_pkg::out_t     out_r;
  uvcr_pkg::out_t     out_nxt;

  // decode stage moves on when the output register is free or draining
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !mem_busy && (!s1_valid_r || s1_adv);
  assign accept   = in_valid && in_ready;

  uvcr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .result  (dec_result),
    .mem_req (mem_req)
  );

  uvcr_edid_mem u_edid_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data),
    .busy    (mem_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= dec_result;
    end
  end

  // edid byte joins here, read data is held until the stage moves
  always_comb begin
    out_nxt.status       = s1_r.status;
    out_nxt.reply_length = s1_r.reply_length;
    out_nxt.short_reply  = s1_r.short_reply;
    out_nxt.data_byte    = s1_r.use_mem ? mem_rd_data : s1_r.data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // store read data must hold while a fetch waits in the decode stage
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> $stable(mem_rd_data))
    else $error("edid read data changed under a stalled fetch");

  // an unsupported request never reports a data stage
  a_stall_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == uvcr_pkg::ST_STALL) |->
      (out_r.reply_length == '0 && !out_r.short_reply && out_r.data_byte == '0))
    else $error("stall result with nonzero length or data");

  // reply bytes only come with fetch results
  a_data_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.data_byte != '0) |-> (out_r.status == uvcr_pkg::ST_DONE))
    else $error("data byte on a setup result");

  // no item enters while the store is being loaded
  a_fill_block: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |=> !s1_valid_r || $past(!mem_busy) || $past(s1_valid_r))
    else $error("item accepted during store load");
`endif

endmodule
